>>> hdl/htfc_pkg.sv
package htfc_pkg;

   // Frame byte positions, in order of arrival.
   typedef enum logic [2:0] {
      POS_TEMP_HI  = 3'd0,
      POS_TEMP_LO  = 3'd1,
      POS_TEMP_CRC = 3'd2,
      POS_HUM_HI   = 3'd3,
      POS_HUM_LO   = 3'd4,
      POS_HUM_CRC  = 3'd5
   } pos_type;

   // CRC-8 settings of the sensor frame.
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // Scaling constants: span in hundredths and offset of the temperature.
   localparam logic [14:0] TEMP_SPAN   = 15'd17500;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;
   localparam logic [13:0] HUM_SPAN    = 14'd10000;
   localparam logic [15:0] FULL_SCALE  = 16'hFFFF;

   // Accepted frame counter width.
   localparam int COUNT_WIDTH = 16;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // Register index on the configuration port.
   localparam logic CSR_IDX_CRC_ENABLE = 1'b0;

   // One assembled frame, handed from the front to the back part.
   typedef struct packed {
      logic [15:0] raw_temperature;
      logic [15:0] raw_humidity;
      logic        temperature_crc_ok;
      logic        humidity_crc_ok;
   } frame_type;

   // One CRC-8 byte step, MSB first.
   function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> hdl/htfc_front.sv
module htfc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_accept,
   input  logic [7:0]           data_byte,
   input  logic                 frame_start,
   output logic                 frame_push,
   output htfc_pkg::frame_type  frame_data
);

   htfc_pkg::pos_type pos_ff, pos_in;
   logic [7:0]        crc_ff, crc_in;
   logic [15:0]       temp_word_ff, temp_word_in;
   logic [15:0]       hum_word_ff, hum_word_in;
   logic              temp_good_ff, temp_good_in;
   htfc_pkg::pos_type pos_now;
   logic [7:0]        crc_step;
   logic              crc_match;

   // The start flag forces the word to byte 0; unused codes also count as byte 0.
   always_comb begin
      if (frame_start) begin
         pos_now = htfc_pkg::POS_TEMP_HI;
      end else begin
         unique case (pos_ff)
            htfc_pkg::POS_TEMP_HI,
            htfc_pkg::POS_TEMP_LO,
            htfc_pkg::POS_TEMP_CRC,
            htfc_pkg::POS_HUM_HI,
            htfc_pkg::POS_HUM_LO,
            htfc_pkg::POS_HUM_CRC: pos_now = pos_ff;
            default:               pos_now = htfc_pkg::POS_TEMP_HI;
         endcase
      end
   end

   // The first byte of each data word starts from the initial CRC value.
   assign crc_step  = htfc_pkg::crc_byte(
      ((pos_now == htfc_pkg::POS_TEMP_HI) || (pos_now == htfc_pkg::POS_HUM_HI)) ?
         htfc_pkg::CRC_INIT : crc_ff, data_byte);
   assign crc_match = (data_byte == crc_ff);

   // Next position, CRC and words for an accepted word.
   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      temp_word_in = temp_word_ff;
      hum_word_in  = hum_word_ff;
      temp_good_in = temp_good_ff;
      frame_push   = 1'b0;
      if (byte_accept) begin
         unique case (pos_now)
            htfc_pkg::POS_TEMP_HI: begin
               crc_in       = crc_step;
               temp_word_in = {data_byte, 8'h00};
               pos_in       = htfc_pkg::POS_TEMP_LO;
            end
            htfc_pkg::POS_TEMP_LO: begin
               crc_in       = crc_step;
               temp_word_in = {temp_word_ff[15:8], data_byte};
               pos_in       = htfc_pkg::POS_TEMP_CRC;
            end
            htfc_pkg::POS_TEMP_CRC: begin
               temp_good_in = crc_match;
               crc_in       = htfc_pkg::CRC_INIT;
               pos_in       = htfc_pkg::POS_HUM_HI;
            end
            htfc_pkg::POS_HUM_HI: begin
               crc_in      = crc_step;
               hum_word_in = {data_byte, 8'h00};
               pos_in      = htfc_pkg::POS_HUM_LO;
            end
            htfc_pkg::POS_HUM_LO: begin
               crc_in      = crc_step;
               hum_word_in = {hum_word_ff[15:8], data_byte};
               pos_in      = htfc_pkg::POS_HUM_CRC;
            end
            default: begin
               frame_push = 1'b1;
               crc_in     = htfc_pkg::CRC_INIT;
               pos_in     = htfc_pkg::POS_TEMP_HI;
            end
         endcase
      end
   end

   // The finished frame goes to the queue together with the last word's check.
   always_comb begin
      frame_data.raw_temperature    = temp_word_ff;
      frame_data.raw_humidity       = hum_word_ff;
      frame_data.temperature_crc_ok = temp_good_ff;
      frame_data.humidity_crc_ok    = crc_match;
   end

   // Position and check state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= htfc_pkg::POS_TEMP_HI;
         crc_ff       <= htfc_pkg::CRC_INIT;
         temp_good_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         temp_good_ff <= temp_good_in;
      end
   end

   // Word registers.
   always_ff @(posedge clock) begin
      temp_word_ff <= temp_word_in;
      hum_word_ff  <= hum_word_in;
   end

endmodule

>>> hdl/htfc_queue.sv
module htfc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  htfc_pkg::frame_type  wr_data,
   output logic                 q_full,
   input  logic                 rd_en,
   output htfc_pkg::frame_type  rd_data,
   output logic                 q_empty
);

   htfc_pkg::frame_type                  entry_ff [htfc_pkg::QUEUE_DEPTH];
   logic [htfc_pkg::QPTR_WIDTH-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [htfc_pkg::QPTR_WIDTH-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [htfc_pkg::QCNT_WIDTH-1:0]      count_ff, count_in;
   logic                                 do_wr, do_rd;

   assign q_full  = (count_ff == htfc_pkg::QCNT_WIDTH'(htfc_pkg::QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == htfc_pkg::QPTR_WIDTH'(htfc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == htfc_pkg::QPTR_WIDTH'(htfc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> hdl/htfc_back.sv
module htfc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 crc_enable,
   input  logic                 q_empty,
   input  htfc_pkg::frame_type  q_data,
   output logic                 q_pop,
   input  logic                 out_pop,
   output logic                 out_valid,
   output logic [15:0]          raw_temperature,
   output logic [15:0]          raw_humidity,
   output logic signed [14:0]   temperature_centi,
   output logic [13:0]          humidity_centi,
   output logic                 temperature_crc_ok,
   output logic                 humidity_crc_ok,
   output logic                 frame_accepted,
   output logic [15:0]          accepted_count
);

   // Product stage.
   logic                              a_valid_ff;
   logic [30:0]                       a_temp_prod_ff;
   logic [29:0]                       a_hum_prod_ff;
   htfc_pkg::frame_type               a_frame_ff;
   logic                              a_accept_ff;
   logic                              a_load, a_advance;

   // Result stage.
   logic                              b_valid_ff;
   logic [15:0]                       b_raw_temp_ff, b_raw_hum_ff;
   logic [14:0]                       b_temp_ff;
   logic [13:0]                       b_hum_ff;
   logic                              b_temp_ok_ff, b_hum_ok_ff, b_accept_ff;
   logic [15:0]                       b_count_ff;

   logic [htfc_pkg::COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [16:0]                       temp_fold, hum_fold;
   logic [14:0]                       temp_quo;
   logic [13:0]                       hum_quo;

   // The result register frees when empty or taken; the product stage moves on then.
   assign a_advance = !b_valid_ff || out_pop;
   assign a_load    = !a_valid_ff || a_advance;
   assign q_pop     = !q_empty && a_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_load) begin
         a_valid_ff <= !q_empty;
      end
   end

   // Scale products and the accept decision.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_frame_ff     <= q_data;
         a_temp_prod_ff <= 31'(q_data.raw_temperature) * 31'(htfc_pkg::TEMP_SPAN);
         a_hum_prod_ff  <= 30'(q_data.raw_humidity) * 30'(htfc_pkg::HUM_SPAN);
         a_accept_ff    <= !crc_enable ||
                           (q_data.temperature_crc_ok && q_data.humidity_crc_ok);
      end
   end

   // Floor division by 65535: with x = q*65536 + r, the quotient is q plus one
   // when q + r reaches 65535, since q + r stays below twice the divisor.
   assign temp_fold = 17'(a_temp_prod_ff[30:16]) + 17'(a_temp_prod_ff[15:0]);
   assign hum_fold  = 17'(a_hum_prod_ff[29:16]) + 17'(a_hum_prod_ff[15:0]);
   assign temp_quo  = a_temp_prod_ff[30:16] +
                      15'(temp_fold >= 17'(htfc_pkg::FULL_SCALE));
   assign hum_quo   = a_hum_prod_ff[29:16] +
                      14'(hum_fold >= 17'(htfc_pkg::FULL_SCALE));

   // Accepted frames advance the wrapping counter as they enter the result stage.
   always_comb begin
      count_in = count_ff;
      if (a_advance && a_valid_ff && a_accept_ff) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         count_ff <= count_in;
         if (a_advance) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (a_advance && a_valid_ff) begin
         b_raw_temp_ff <= a_frame_ff.raw_temperature;
         b_raw_hum_ff  <= a_frame_ff.raw_humidity;
         b_temp_ff     <= temp_quo - htfc_pkg::TEMP_OFFSET;
         b_hum_ff      <= hum_quo;
         b_temp_ok_ff  <= a_frame_ff.temperature_crc_ok;
         b_hum_ok_ff   <= a_frame_ff.humidity_crc_ok;
         b_accept_ff   <= a_accept_ff;
         b_count_ff    <= 16'(count_in);
      end
   end

   assign out_valid          = b_valid_ff;
   assign raw_temperature    = b_raw_temp_ff;
   assign raw_humidity       = b_raw_hum_ff;
   assign temperature_centi  = signed'(b_temp_ff);
   assign humidity_centi     = b_hum_ff;
   assign temperature_crc_ok = b_temp_ok_ff;
   assign humidity_crc_ok    = b_hum_ok_ff;
   assign frame_accepted     = b_accept_ff;
   assign accepted_count     = b_count_ff;

endmodule

>>> hdl/humidity_temp_frame_checker_top.sv
// Channel  | Ports                                  | Word
// ---------+----------------------------------------+-------------------------------------
// Input    | push, full, req_*                      | one frame byte and its start flag
// Result   | empty, pop, rsp_*                      | one checked and scaled frame
// Config   | psel, penable, pwrite, paddr, pwdata,  | crc_enable at byte address 0
//          | prdata, pready                         |
//
// One byte word is taken every cycle while push is high and the frame queue has
// room; a frame completes on its sixth byte. The frame then passes through the
// frame queue, the scaling product register and the result register to the result ports.
// Synchronous reset clears position, CRC, queue, pipeline and counter.
// full rises only while the two-entry frame queue holds two frames, which
// happens only when the result side stops popping.
module humidity_temp_frame_checker_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [7:0]          req_data_byte,
   input  logic                req_frame_start,
   output logic                empty,
   input  logic                pop,
   output logic [15:0]         rsp_raw_temperature,
   output logic [15:0]         rsp_raw_humidity,
   output logic signed [14:0]  rsp_temperature_centi,
   output logic [13:0]         rsp_humidity_centi,
   output logic                rsp_temperature_crc_ok,
   output logic                rsp_humidity_crc_ok,
   output logic                rsp_frame_accepted,
   output logic [15:0]         rsp_accepted_count,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   logic                 crc_enable_ff;
   logic                 byte_accept;
   logic                 frame_push;
   htfc_pkg::frame_type  frame_data;
   logic                 q_full, q_empty, q_pop;
   htfc_pkg::frame_type  q_data;
   logic                 out_valid;

   // Configuration register.
   assign pready = 1'b1;
   assign prdata = (paddr[2] == htfc_pkg::CSR_IDX_CRC_ENABLE) ? 32'(crc_enable_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_enable_ff <= 1'b1;
      end else if (psel && penable && pwrite && pready &&
                   (paddr[2] == htfc_pkg::CSR_IDX_CRC_ENABLE)) begin
         crc_enable_ff <= pwdata[0];
      end
   end

   // Input side takes a word whenever the frame queue has room.
   assign full        = q_full;
   assign byte_accept = push && !q_full;

   htfc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .data_byte   (req_data_byte),
      .frame_start (req_frame_start),
      .frame_push  (frame_push),
      .frame_data  (frame_data)
   );

   htfc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (frame_push),
      .wr_data (frame_data),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .q_empty (q_empty)
   );

   htfc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .crc_enable         (crc_enable_ff),
      .q_empty            (q_empty),
      .q_data             (q_data),
      .q_pop              (q_pop),
      .out_pop            (pop),
      .out_valid          (out_valid),
      .raw_temperature    (rsp_raw_temperature),
      .raw_humidity       (rsp_raw_humidity),
      .temperature_centi  (rsp_temperature_centi),
      .humidity_centi     (rsp_humidity_centi),
      .temperature_crc_ok (rsp_temperature_crc_ok),
      .humidity_crc_ok    (rsp_humidity_crc_ok),
      .frame_accepted     (rsp_frame_accepted),
      .accepted_count     (rsp_accepted_count)
   );

   assign empty = !out_valid;

endmodule

>>> hdl/htfc_checker.sv
module htfc_checker (
   input logic                clock,
   input logic                reset,
   input logic                empty,
   input logic                pop,
   input logic [15:0]         rsp_raw_temperature,
   input logic [15:0]         rsp_raw_humidity,
   input logic signed [14:0]  rsp_temperature_centi,
   input logic [13:0]         rsp_humidity_centi,
   input logic                rsp_temperature_crc_ok,
   input logic                rsp_humidity_crc_ok,
   input logic                rsp_frame_accepted,
   input logic [15:0]         rsp_accepted_count
);

   // Reset leaves no result waiting.
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result waiting after reset");

   // A waiting result that is not taken stays put.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_raw_temperature) &&
                            $stable(rsp_raw_humidity) && $stable(rsp_accepted_count)))
      else $error("waiting result changed before it was taken");

   // Two good checks always accept the frame.
   a_good_frame_accepted: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_temperature_crc_ok && rsp_humidity_crc_ok) |-> rsp_frame_accepted)
      else $error("frame with good checks rejected");

   // Full-scale raw words map to the top of both scales.
   a_full_scale: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_raw_humidity == 16'hFFFF && rsp_raw_temperature == 16'hFFFF) |->
      (rsp_humidity_centi == 14'd10000 && rsp_temperature_centi == 15'sd13000))
      else $error("full-scale conversion wrong");

endmodule

bind humidity_temp_frame_checker_top htfc_checker u_checker (.*);

>>> test/tb_humidity_temp_frame_checker_top.sv
module tb_humidity_temp_frame_checker_top;

   timeunit 1ns;
   timeprecision 1ps;

   // Byte address of the CRC enable register.
   localparam logic [2:0] CRC_ENABLE_ADDR = {htfc_pkg::CSR_IDX_CRC_ENABLE, 2'b00};
   // Cycles allowed after the last result for a frame still in the pipeline.
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_BYTES = 1050;
   localparam int RANDOM_PHASES = 6;

   // One checked frame as it leaves the block.
   typedef struct {
      logic [15:0]        raw_temperature;
      logic [15:0]        raw_humidity;
      logic signed [14:0] temperature_centi;
      logic [13:0]        humidity_centi;
      logic               temperature_crc_ok;
      logic               humidity_crc_ok;
      logic               frame_accepted;
      logic [15:0]        accepted_count;
   } measurement_type;

   // Tracks frame assembly byte by byte and keeps the measurements still owed.
   class frame_ledger;
      bit                               crc_enable;
      htfc_pkg::pos_type                position;
      logic [7:0]                       running_crc;
      logic [15:0]                      temp_word;
      logic [15:0]                      hum_word;
      logic                             temp_good;
      logic [htfc_pkg::COUNT_WIDTH-1:0] accepted_frames;
      measurement_type                  owed[$];
      int                               mismatches;

      function new();
         crc_enable = 1'b1;
         position = htfc_pkg::POS_TEMP_HI;
         running_crc = htfc_pkg::CRC_INIT;
         temp_word = '0;
         hum_word = '0;
         temp_good = 1'b0;
         accepted_frames = '0;
         mismatches = 0;
      endfunction

      // CRC-8 over one byte, feeding the data in bit by bit from the top.
      static function logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] data);
         logic [7:0] c;
         logic       feedback;
         c = crc;
         for (int i = 7; i >= 0; i--) begin
            feedback = c[7] ^ data[i];
            c = {c[6:0], 1'b0};
            if (feedback) begin
               c = c ^ htfc_pkg::CRC_POLY;
            end
         end
         return c;
      endfunction

      static function logic [7:0] word_crc(logic [15:0] word);
         return crc8_step(crc8_step(htfc_pkg::CRC_INIT, word[15:8]), word[7:0]);
      endfunction

      function void set_crc_enable(bit value);
         crc_enable = value;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // Advances the frame position with one accepted byte word.
      function void take_byte(logic [7:0] data, logic start);
         htfc_pkg::pos_type pos;
         logic              hum_good;
         logic              accept;
         int unsigned       scaled_t;
         int unsigned       scaled_h;
         int                centi_t;
         measurement_type   m;
         pos = start ? htfc_pkg::POS_TEMP_HI : position;
         case (pos)
            htfc_pkg::POS_TEMP_HI: begin
               running_crc = crc8_step(htfc_pkg::CRC_INIT, data);
               temp_word = {data, 8'h00};
               position = htfc_pkg::POS_TEMP_LO;
            end
            htfc_pkg::POS_TEMP_LO: begin
               running_crc = crc8_step(running_crc, data);
               temp_word[7:0] = data;
               position = htfc_pkg::POS_TEMP_CRC;
            end
            htfc_pkg::POS_TEMP_CRC: begin
               temp_good = (data == running_crc);
               running_crc = htfc_pkg::CRC_INIT;
               position = htfc_pkg::POS_HUM_HI;
            end
            htfc_pkg::POS_HUM_HI: begin
               running_crc = crc8_step(htfc_pkg::CRC_INIT, data);
               hum_word = {data, 8'h00};
               position = htfc_pkg::POS_HUM_LO;
            end
            htfc_pkg::POS_HUM_LO: begin
               running_crc = crc8_step(running_crc, data);
               hum_word[7:0] = data;
               position = htfc_pkg::POS_HUM_CRC;
            end
            htfc_pkg::POS_HUM_CRC: begin
               hum_good = (data == running_crc);
               accept = !crc_enable || (temp_good && hum_good);
               if (accept) begin
                  accepted_frames = accepted_frames + 1'b1;
               end
               // Floor division by full scale, done in 32-bit unsigned.
               scaled_t = (32'd17500 * 32'(temp_word)) / 32'd65535;
               scaled_h = (32'd10000 * 32'(hum_word)) / 32'd65535;
               centi_t = int'(scaled_t) - 4500;
               m.raw_temperature = temp_word;
               m.raw_humidity = hum_word;
               m.temperature_centi = 15'(centi_t);
               m.humidity_centi = 14'(scaled_h);
               m.temperature_crc_ok = temp_good;
               m.humidity_crc_ok = hum_good;
               m.frame_accepted = accept;
               m.accepted_count = 16'(accepted_frames);
               owed.push_back(m);
               running_crc = htfc_pkg::CRC_INIT;
               position = htfc_pkg::POS_TEMP_HI;
            end
         endcase
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) begin
            report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
         end
      endtask

      // Compares a popped measurement with the oldest one owed.
      task check_frame(measurement_type got);
         measurement_type want;
         if (owed.size() == 0) begin
            report("measurement popped with no frame completed");
         end else begin
            want = owed.pop_front();
            check_field("raw_temperature", 32'(got.raw_temperature),
                        32'(want.raw_temperature));
            check_field("raw_humidity", 32'(got.raw_humidity), 32'(want.raw_humidity));
            check_field("temperature_centi", 32'(got.temperature_centi),
                        32'(want.temperature_centi));
            check_field("humidity_centi", 32'(got.humidity_centi),
                        32'(want.humidity_centi));
            check_field("temperature_crc_ok", 32'(got.temperature_crc_ok),
                        32'(want.temperature_crc_ok));
            check_field("humidity_crc_ok", 32'(got.humidity_crc_ok),
                        32'(want.humidity_crc_ok));
            check_field("frame_accepted", 32'(got.frame_accepted),
                        32'(want.frame_accepted));
            check_field("accepted_count", 32'(got.accepted_count),
                        32'(want.accepted_count));
         end
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               push;
   logic               full;
   logic [7:0]         req_data_byte;
   logic               req_frame_start;
   logic               empty;
   logic               pop;
   logic [15:0]        rsp_raw_temperature;
   logic [15:0]        rsp_raw_humidity;
   logic signed [14:0] rsp_temperature_centi;
   logic [13:0]        rsp_humidity_centi;
   logic               rsp_temperature_crc_ok;
   logic               rsp_humidity_crc_ok;
   logic               rsp_frame_accepted;
   logic [15:0]        rsp_accepted_count;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [2:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   frame_ledger ledger = new();
   bit          send_gaps;
   bit          pop_stalls;
   int          bytes_sent;

   humidity_temp_frame_checker_top dut (
      .clock                  (clock),
      .reset                  (reset),
      .push                   (push),
      .full                   (full),
      .req_data_byte          (req_data_byte),
      .req_frame_start        (req_frame_start),
      .empty                  (empty),
      .pop                    (pop),
      .rsp_raw_temperature    (rsp_raw_temperature),
      .rsp_raw_humidity       (rsp_raw_humidity),
      .rsp_temperature_centi  (rsp_temperature_centi),
      .rsp_humidity_centi     (rsp_humidity_centi),
      .rsp_temperature_crc_ok (rsp_temperature_crc_ok),
      .rsp_humidity_crc_ok    (rsp_humidity_crc_ok),
      .rsp_frame_accepted     (rsp_frame_accepted),
      .rsp_accepted_count     (rsp_accepted_count),
      .psel                   (psel),
      .penable                (penable),
      .pwrite                 (pwrite),
      .paddr                  (paddr),
      .pwdata                 (pwdata),
      .prdata                 (prdata),
      .pready                 (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Words near the ends of the range turn up more often than chance gives.
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Holds one byte word on the input until the block takes it.
   task automatic send_byte(logic [7:0] data, logic start);
      int gap;
      gap = send_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_data_byte <= data;
      req_frame_start <= start;
      @(posedge clock);
      while (full) @(posedge clock);
      ledger.take_byte(data, start);
      bytes_sent++;
   endtask

   // Sends a six-byte frame; a CRC marked bad is corrupted by a non-zero mask.
   task automatic send_frame(logic [15:0] temp, logic [15:0] hum, bit temp_ok, bit hum_ok,
                             logic start);
      logic [7:0] temp_crc;
      logic [7:0] hum_crc;
      temp_crc = frame_ledger::word_crc(temp);
      hum_crc = frame_ledger::word_crc(hum);
      if (!temp_ok) begin
         temp_crc = temp_crc ^ 8'($urandom_range(1, 255));
      end
      if (!hum_ok) begin
         hum_crc = hum_crc ^ 8'($urandom_range(1, 255));
      end
      send_byte(temp[15:8], start);
      send_byte(temp[7:0], 1'b0);
      send_byte(temp_crc, 1'b0);
      send_byte(hum[15:8], 1'b0);
      send_byte(hum[7:0], 1'b0);
      send_byte(hum_crc, 1'b0);
   endtask

   // Stops sending and waits until every owed measurement has been popped.
   task automatic drain();
      push <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CRC_ENABLE_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      ledger.set_crc_enable(value[0]);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check();
      logic [31:0] want;
      want = {31'b0, ledger.crc_enable};
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= CRC_ENABLE_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want) begin
         ledger.report($sformatf("crc_enable read 0x%0h expected 0x%0h", prdata, want));
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Pops measurement words with random stalls and checks each one.
   initial begin
      int              gap;
      measurement_type got;
      pop <= 1'b0;
      @(negedge reset);
      forever begin
         gap = pop_stalls ? pick_gap() : 0;
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         got.raw_temperature = rsp_raw_temperature;
         got.raw_humidity = rsp_raw_humidity;
         got.temperature_centi = rsp_temperature_centi;
         got.humidity_centi = rsp_humidity_centi;
         got.temperature_crc_ok = rsp_temperature_crc_ok;
         got.humidity_crc_ok = rsp_humidity_crc_ok;
         got.frame_accepted = rsp_frame_accepted;
         got.accepted_count = rsp_accepted_count;
         ledger.check_frame(got);
      end
   end

   // Main sequence: directed frames, then random phases.
   initial begin
      int target;
      reset <= 1'b1;
      push <= 1'b0;
      req_data_byte <= '0;
      req_frame_start <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      send_gaps = 1'b1;
      pop_stalls = 1'b1;
      bytes_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The register comes out of reset with checking on.
      csr_read_check();

      // Extreme words with good CRCs, the start flag on byte 0 and left off.
      send_frame(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1);
      send_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
      // A partial frame cut short by a start flag, then rejected frames.
      send_byte(8'h12, 1'b1);
      send_byte(8'h34, 1'b0);
      send_frame(16'hBEEF, 16'h8000, 1'b0, 1'b1, 1'b1);
      send_frame(16'h0001, 16'h7FFF, 1'b1, 1'b0, 1'b0);
      drain();

      // Random phases, alternating checking on and off with noise in the upper bits.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         csr_write({$urandom_range(0, 1) ? 31'($urandom) : 31'b0, phase[0] == 1'b0});
         csr_read_check();
         send_gaps = (phase == 0) || ($urandom_range(0, 3) != 0);
         pop_stalls = (phase == 0) || ($urandom_range(0, 3) != 0);
         target = bytes_sent + RANDOM_BYTES / RANDOM_PHASES;
         while (bytes_sent < target) begin
            if ($urandom_range(0, 9) < 8) begin
               send_frame(pick_word(), pick_word(), $urandom_range(0, 3) != 0,
                          $urandom_range(0, 3) != 0, $urandom_range(0, 9) < 7);
            end else begin
               // Broken frames: a few random bytes with stray start flags.
               repeat ($urandom_range(1, 5)) begin
                  send_byte(8'($urandom), $urandom_range(0, 3) == 0);
               end
            end
         end
         drain();
      end

      if (ledger.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
